@@ src/dbap_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the ping-pong audio playback buffer
package dbap_pkg;

    // command classes, coded as on the input channel
    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_FILL  = 3'd1,
        CMD_EOS   = 3'd2,
        CMD_TICK  = 3'd3,
        CMD_TIME  = 3'd4,
        CMD_NOP   = 3'd5
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data_byte;
        logic       frame_end;
    } t_item;

    // playback state, one-hot
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_RUN   = 3'b010,
        MODE_DRAIN = 3'b100
    } t_mode;

    // play_mode codes on the result channel
    localparam logic [1:0] PLAY_IDLE  = 2'd0;
    localparam logic [1:0] PLAY_RUN   = 2'd1;
    localparam logic [1:0] PLAY_DRAIN = 2'd2;

    localparam logic [3:0]  DAC_CMD_NIBBLE = 4'h3;
    localparam logic [7:0]  PAD_BYTE       = 8'h80;
    localparam logic [15:0] MUTE_DELAY_RST = 16'd2000;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

@@ src/dbap_in_if.sv @@
`timescale 1ns / 1ps
// input item channel
interface dbap_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, command, data_byte, frame_end, input ready);
    modport sink   (input valid, command, data_byte, frame_end, output ready);
endinterface

@@ src/dbap_out_if.sv @@
`timescale 1ns / 1ps
// result item channel
interface dbap_out_if;
    logic        valid;
    logic        ready;
    logic        dac_valid;
    logic [15:0] dac_word;
    logic        byte_accepted;
    logic        play_finished;
    logic        amp_enabled;
    logic [1:0]  play_mode;
    logic [15:0] underflow_total;

    modport source (output valid, dac_valid, dac_word, byte_accepted, play_finished,
                    amp_enabled, play_mode, underflow_total, input ready);
    modport sink   (input valid, dac_valid, dac_word, byte_accepted, play_finished,
                    amp_enabled, play_mode, underflow_total, output ready);
endinterface

@@ src/dbap_cfg_if.sv @@
`timescale 1ns / 1ps
// configuration write channel
interface dbap_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] mute_delay_ticks;

    modport source (output valid, mute_delay_ticks, input ready);
    modport sink   (input valid, mute_delay_ticks, output ready);
endinterface

@@ src/dbap_front.sv @@
`timescale 1ns / 1ps
// command decode and two-entry queue ahead of the playback engine
module dbap_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dbap_in_if.sink          i_in,
    output logic             o_item_valid,
    output dbap_pkg::t_item  o_item,
    input  logic             i_item_pop
);

    dbap_pkg::t_item                    r_q [dbap_pkg::QUEUE_DEPTH];
    logic [dbap_pkg::QPTR_W-1:0]        r_wp;
    logic [dbap_pkg::QPTR_W-1:0]        r_rp;
    logic [dbap_pkg::QCNT_W-1:0]        r_cnt;
    logic [dbap_pkg::QCNT_W-1:0]        n_cnt;
    dbap_pkg::t_item                    item_in;
    logic                               push;
    logic                               pop;

    // unused codes become a no-op class
    always_comb begin
        item_in.data_byte = i_in.data_byte;
        item_in.frame_end = i_in.frame_end;
        if (i_in.command <= 3'(dbap_pkg::CMD_TIME)) begin
            item_in.cmd = dbap_pkg::t_cmd'(i_in.command);
        end else begin
            item_in.cmd = dbap_pkg::CMD_NOP;
        end
    end

    assign i_in.ready   = (r_cnt != dbap_pkg::QCNT_W'(dbap_pkg::QUEUE_DEPTH));
    assign push         = i_in.valid && i_in.ready;
    assign o_item_valid = (r_cnt != '0);
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + dbap_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - dbap_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= r_wp + dbap_pkg::QPTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + dbap_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item_in;
        end
    end

endmodule

@@ src/dbap_back.sv @@
`timescale 1ns / 1ps
// playback engine: frame state, sample store, result pipeline
module dbap_back #(
    parameter int FRAME_BYTES = 128,
    parameter int SAMPLE_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    input  dbap_pkg::t_item  i_item,
    output logic             o_item_pop,
    dbap_cfg_if.sink         i_cfg,
    dbap_out_if.source       o_out
);

    localparam int BPS   = (SAMPLE_BITS >= 16) ? 2 : 1;
    localparam int IDX_W = $clog2(FRAME_BYTES);
    localparam int LEN_W = $clog2(FRAME_BYTES + 1);
    localparam int CHK_W = $clog2(FRAME_BYTES + 2 * BPS + 1);
    localparam int MEM_D = 2 ** (IDX_W + 1);
    localparam logic [LEN_W-1:0] FB_LEN = LEN_W'(FRAME_BYTES);
    localparam logic [CHK_W-1:0] FB_CHK = CHK_W'(FRAME_BYTES);
    localparam logic [CHK_W-1:0] STEP2  = CHK_W'(2 * BPS);
    localparam logic [IDX_W-1:0] STEP1  = IDX_W'(BPS);

    typedef struct packed {
        logic        dac_valid;
        logic        accepted;
        logic        finished;
        logic        amp;
        logic [1:0]  mode;
        logic [15:0] underflow;
        logic        pad_lo;
        logic        pad_hi;
    } t_stage;

    // frame and play state
    logic [15:0]          r_mute;
    logic [1:0]           r_ready, n_ready;
    logic [LEN_W-1:0]     r_len [2];
    logic [LEN_W-1:0]     n_len [2];
    logic                 r_ps, n_ps;
    logic [IDX_W-1:0]     r_pos, n_pos;
    logic                 r_fs, n_fs;
    logic [IDX_W-1:0]     r_fpos, n_fpos;
    logic [15:0]          r_uf, n_uf;
    dbap_pkg::t_mode      r_mode, n_mode;
    logic                 r_amp, n_amp;
    logic [15:0]          r_idle, n_idle;

    // sample store
    logic [7:0]           r_mem [MEM_D];
    logic [7:0]           r_rd_lo;
    logic [7:0]           r_rd_hi;
    logic                 mem_we;
    logic [IDX_W:0]       wr_addr;
    logic [IDX_W:0]       rd_addr_lo;
    logic [IDX_W:0]       rd_addr_hi;

    // pipeline
    logic                 fire;
    logic                 out_free;
    logic                 s2_adv;
    logic                 r_s2_valid;
    t_stage               r_s2, n_s2;
    logic                 r_out_valid;
    logic [15:0]          dac_word;
    logic [7:0]           b_lo, b_hi;
    logic [11:0]          sample12;

    // scratch
    logic [LEN_W-1:0]     fill_next;
    logic [LEN_W-1:0]     pos_next;
    logic [CHK_W-1:0]     pos_chk;
    logic [1:0]           mode_code;

    assign out_free   = !r_out_valid || o_out.ready;
    assign s2_adv     = r_s2_valid && out_free;
    assign fire       = i_item_valid && (!r_s2_valid || out_free);
    assign o_item_pop = fire;

    assign fill_next  = LEN_W'(r_fpos) + LEN_W'(1);
    assign pos_next   = LEN_W'(r_pos) + LEN_W'(1);
    assign pos_chk    = CHK_W'(r_pos) + STEP2;
    assign wr_addr    = {r_fs, r_fpos};
    assign rd_addr_lo = {r_ps, r_pos};
    assign rd_addr_hi = {r_ps, pos_next[IDX_W-1:0]};

    assign i_cfg.ready = 1'b1;

    // one item of work on the current state
    always_comb begin
        n_ready = r_ready;
        n_len   = r_len;
        n_ps    = r_ps;
        n_pos   = r_pos;
        n_fs    = r_fs;
        n_fpos  = r_fpos;
        n_uf    = r_uf;
        n_mode  = r_mode;
        n_amp   = r_amp;
        n_idle  = r_idle;
        mem_we  = 1'b0;
        n_s2    = '0;
        n_s2.pad_lo = (LEN_W'(r_pos) >= r_len[r_ps]);
        n_s2.pad_hi = (pos_next >= r_len[r_ps]);

        unique case (i_item.cmd)
            dbap_pkg::CMD_START: begin
                n_ready = 2'b00;
                n_ps    = 1'b0;
                n_pos   = '0;
                n_fpos  = '0;
                n_idle  = '0;
                n_amp   = 1'b1;
                n_mode  = dbap_pkg::MODE_RUN;
            end
            dbap_pkg::CMD_FILL: begin
                if (r_mode == dbap_pkg::MODE_RUN && !r_ready[r_fs]) begin
                    mem_we        = fire;
                    n_s2.accepted = 1'b1;
                    if (i_item.frame_end || fill_next >= FB_LEN) begin
                        n_len[r_fs]   = fill_next;
                        n_ready[r_fs] = 1'b1;
                        n_fs          = !r_fs;
                        n_fpos        = '0;
                    end else begin
                        n_fpos = fill_next[IDX_W-1:0];
                    end
                end
            end
            dbap_pkg::CMD_EOS: begin
                if (r_mode == dbap_pkg::MODE_RUN) begin
                    // close a partly filled frame
                    if (r_fpos != '0 && !r_ready[r_fs]) begin
                        n_len[r_fs]   = LEN_W'(r_fpos);
                        n_ready[r_fs] = 1'b1;
                        n_fs          = !r_fs;
                        n_fpos        = '0;
                    end
                    n_mode = dbap_pkg::MODE_DRAIN;
                end
            end
            dbap_pkg::CMD_TICK: begin
                if (r_mode != dbap_pkg::MODE_IDLE) begin
                    if (r_ready[r_ps]) begin
                        n_s2.dac_valid = 1'b1;
                        if (pos_chk > FB_CHK) begin
                            n_ready[r_ps] = 1'b0;
                            n_ps          = !r_ps;
                            n_pos         = '0;
                        end else begin
                            n_pos = r_pos + STEP1;
                        end
                    end else begin
                        // underflow: skip to the other frame
                        n_ps  = !r_ps;
                        n_pos = '0;
                        if (r_uf != dbap_pkg::COUNT_MAX) begin
                            n_uf = r_uf + 16'd1;
                        end
                    end
                end
            end
            dbap_pkg::CMD_TIME: begin
                if (r_mode == dbap_pkg::MODE_IDLE && r_idle != dbap_pkg::COUNT_MAX) begin
                    n_idle = r_idle + 16'd1;
                end
            end
            default: begin
            end
        endcase

        // drain completion takes precedence over the mute check
        if (i_item.cmd != dbap_pkg::CMD_EOS && n_mode == dbap_pkg::MODE_DRAIN &&
            n_ready == 2'b00) begin
            n_mode        = dbap_pkg::MODE_IDLE;
            n_idle        = '0;
            n_s2.finished = 1'b1;
        end else if (n_mode == dbap_pkg::MODE_IDLE && n_idle > r_mute) begin
            n_amp = 1'b0;
        end

        n_s2.amp       = n_amp;
        n_s2.mode      = mode_code;
        n_s2.underflow = n_uf;
    end

    always_comb begin
        unique case (n_mode)
            dbap_pkg::MODE_RUN:   mode_code = dbap_pkg::PLAY_RUN;
            dbap_pkg::MODE_DRAIN: mode_code = dbap_pkg::PLAY_DRAIN;
            default:              mode_code = dbap_pkg::PLAY_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mute  <= dbap_pkg::MUTE_DELAY_RST;
            r_ready <= 2'b00;
            r_len   <= '{default: '0};
            r_ps    <= 1'b0;
            r_pos   <= '0;
            r_fs    <= 1'b0;
            r_fpos  <= '0;
            r_uf    <= '0;
            r_mode  <= dbap_pkg::MODE_IDLE;
            r_amp   <= 1'b0;
            r_idle  <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_mute <= i_cfg.mute_delay_ticks;
            end
            if (fire) begin
                r_ready <= n_ready;
                r_len   <= n_len;
                r_ps    <= n_ps;
                r_pos   <= n_pos;
                r_fs    <= n_fs;
                r_fpos  <= n_fpos;
                r_uf    <= n_uf;
                r_mode  <= n_mode;
                r_amp   <= n_amp;
                r_idle  <= n_idle;
            end
        end
    end

    // store write and registered two-byte read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= i_item.data_byte;
        end
        if (fire) begin
            r_rd_lo <= r_mem[rd_addr_lo];
            r_rd_hi <= r_mem[rd_addr_hi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (fire) begin
            r_s2_valid <= 1'b1;
        end else if (s2_adv) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s2 <= n_s2;
        end
    end

    // sample formatting from the read data
    assign b_lo     = r_s2.pad_lo ? dbap_pkg::PAD_BYTE : r_rd_lo;
    assign b_hi     = r_s2.pad_hi ? dbap_pkg::PAD_BYTE : r_rd_hi;
    assign sample12 = (BPS == 2) ? {b_hi, b_lo[7:4]} : {b_lo, 4'h0};
    assign dac_word = r_s2.dac_valid ? {dbap_pkg::DAC_CMD_NIBBLE, sample12} : 16'h0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            o_out.dac_valid       <= r_s2.dac_valid;
            o_out.dac_word        <= dac_word;
            o_out.byte_accepted   <= r_s2.accepted;
            o_out.play_finished   <= r_s2.finished;
            o_out.amp_enabled     <= r_s2.amp;
            o_out.play_mode       <= r_s2.mode;
            o_out.underflow_total <= r_s2.underflow;
        end
    end

    assign o_out.valid = r_out_valid;

`ifndef ASSERT_OFF
    a_idle_no_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == dbap_pkg::MODE_IDLE |-> r_ready == 2'b00)
        else $error("frame flagged ready while idle");

    a_underflow_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_uf >= $past(r_uf))
        else $error("underflow count went down");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && !out_free |=> r_s2_valid && $stable(r_s2))
        else $error("stalled stage overwritten");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_s2.finished |-> r_s2.mode == dbap_pkg::PLAY_IDLE)
        else $error("finish reported without stopping");
`endif

endmodule

@@ src/double_buffer_audio_player.sv @@
`timescale 1ns / 1ps
// ping-pong audio playback buffer, top level
//
// usage notes
// - i_in: one command per transfer (start, fill byte, end of stream,
//   sample tick, time tick); codes 5 to 7 only run the drain and mute checks
// - o_out: exactly one result transfer per input transfer, in order
// - i_cfg: writes mute_delay_ticks, always ready; write only with no
//   transfer in flight
// - path: a result passes the command queue, the engine stage and the output register
// - throughput: one item per cycle unless the receiver stalls; the engine takes one
//   queued item each cycle, set by the frame state that every item reads and updates in turn
// - reset: idle, amplifier muted, mute delay 2000, frames not ready,
//   sample store contents undefined until filled
// - receiver stall: the output register and the engine stage hold, then the
//   two-entry command queue fills and i_in.ready drops
module double_buffer_audio_player #(
    parameter int FRAME_BYTES = 128,
    parameter int SAMPLE_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dbap_in_if.sink     i_in,
    dbap_cfg_if.sink    i_cfg,
    dbap_out_if.source  o_out
);

    // queue head towards the engine
    logic            item_valid;
    dbap_pkg::t_item item;
    logic            item_pop;

    // front: decode and buffer commands
    dbap_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    // back: frame state, sample store and result register
    dbap_back #(
        .FRAME_BYTES (FRAME_BYTES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .i_cfg        (i_cfg),
        .o_out        (o_out)
    );

endmodule

@@ bench/tb_double_buffer_audio_player.sv @@
`timescale 1ns / 1ps
// self-checking bench for the ping-pong audio playback buffer
module tb_double_buffer_audio_player;

    // block configuration under test
    localparam int FRAME_BYTES  = 128;
    localparam int SAMPLE_BITS  = 8;
    localparam int SAMPLE_BYTES = (SAMPLE_BITS >= 16) ? 2 : 1;

    // command codes with no function, they only run the drain and mute checks
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    // chance in a hundred that a side idles on a given cycle
    localparam int GAP_PCT      = 16;
    localparam int RANDOM_ITEMS = 620;
    // a correct run ends well within this limit, allowing for gaps on both
    // sides
    localparam int CYCLE_LIMIT  = 50_000;
    localparam int PRINT_LIMIT  = 200;

    // one result transfer as the block should present it
    typedef struct packed {
        logic        dac_valid;
        logic [15:0] dac_word;
        logic        byte_accepted;
        logic        play_finished;
        logic        amp_enabled;
        logic [1:0]  play_mode;
        logic [15:0] underflow_total;
    } t_player_out;

    logic i_clk;
    logic i_rst_n;

    dbap_in_if  in_if ();
    dbap_cfg_if cfg_if ();
    dbap_out_if out_if ();

    double_buffer_audio_player #(
        .FRAME_BYTES(FRAME_BYTES),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .i_cfg  (cfg_if),
        .o_out  (out_if)
    );

    // ------------------------------------------------------------------
    // player state as the bench tracks it
    // ------------------------------------------------------------------
    logic [7:0]  frame_mem [2][FRAME_BYTES];
    logic [7:0]  frame_len [2];
    bit          frame_full [2];     // frame waiting to be played
    bit          play_sel;
    logic [7:0]  play_idx;
    bit          fill_sel;
    logic [7:0]  fill_idx;
    logic [15:0] underflows;
    logic [15:0] idle_count;
    logic [15:0] mute_delay;
    logic [1:0]  player_mode;
    bit          amp_power;

    // results still owed by the block, oldest first
    t_player_out pending_outputs [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    bit steady;                      // suppresses idling on both sides

    function automatic void player_reset();
        frame_len[0]  = '0;
        frame_len[1]  = '0;
        frame_full[0] = 1'b0;
        frame_full[1] = 1'b0;
        play_sel      = 1'b0;
        play_idx      = '0;
        fill_sel      = 1'b0;
        fill_idx      = '0;
        underflows    = '0;
        idle_count    = '0;
        mute_delay    = dbap_pkg::MUTE_DELAY_RST;
        player_mode   = dbap_pkg::PLAY_IDLE;
        amp_power     = 1'b0;
    endfunction

    // bytes past the recorded length of a short frame read as silence
    function automatic logic [7:0] frame_byte(input bit side, input int idx);
        if (idx >= FRAME_BYTES || idx >= int'(frame_len[side]))
            return dbap_pkg::PAD_BYTE;
        return frame_mem[side][idx];
    endfunction

    function automatic void close_fill();
        frame_len[fill_sel]  = fill_idx;
        frame_full[fill_sel] = 1'b1;
        fill_sel             = !fill_sel;
        fill_idx             = '0;
    endfunction

    // advances the tracked state by one command and returns the result it causes
    function automatic t_player_out player_step(input logic [2:0] cmd,
                                                input logic [7:0] data,
                                                input logic       fend);
        t_player_out res;
        logic [15:0] pair;
        res = '0;
        case (cmd)
            dbap_pkg::CMD_START: begin
                frame_full[0] = 1'b0;
                frame_full[1] = 1'b0;
                play_sel      = 1'b0;
                play_idx      = '0;
                fill_idx      = '0;
                idle_count    = '0;
                amp_power     = 1'b1;
                player_mode   = dbap_pkg::PLAY_RUN;
            end
            dbap_pkg::CMD_FILL: begin
                if (player_mode == dbap_pkg::PLAY_RUN && !frame_full[fill_sel] &&
                    int'(fill_idx) < FRAME_BYTES) begin
                    frame_mem[fill_sel][fill_idx] = data;
                    fill_idx          = fill_idx + 8'd1;
                    res.byte_accepted = 1'b1;
                    if (fend || int'(fill_idx) >= FRAME_BYTES)
                        close_fill();
                end
            end
            dbap_pkg::CMD_EOS: begin
                if (player_mode == dbap_pkg::PLAY_RUN) begin
                    if (fill_idx != 0 && !frame_full[fill_sel])
                        close_fill();
                    player_mode = dbap_pkg::PLAY_DRAIN;
                end
            end
            dbap_pkg::CMD_TICK: begin
                if (player_mode == dbap_pkg::PLAY_RUN ||
                    player_mode == dbap_pkg::PLAY_DRAIN) begin
                    if (frame_full[play_sel]) begin
                        if (SAMPLE_BYTES == 2) begin
                            pair = {frame_byte(play_sel, int'(play_idx) + 1),
                                    frame_byte(play_sel, int'(play_idx))};
                            res.dac_word = {dbap_pkg::DAC_CMD_NIBBLE, pair[15:4]};
                        end else begin
                            res.dac_word = {dbap_pkg::DAC_CMD_NIBBLE,
                                            frame_byte(play_sel, int'(play_idx)), 4'h0};
                        end
                        res.dac_valid = 1'b1;
                        if (int'(play_idx) + 2 * SAMPLE_BYTES > FRAME_BYTES) begin
                            frame_full[play_sel] = 1'b0;
                            play_sel             = !play_sel;
                            play_idx             = '0;
                        end else begin
                            play_idx = play_idx + 8'(SAMPLE_BYTES);
                        end
                    end else begin
                        // nothing to play, look at the other frame next time
                        play_sel = !play_sel;
                        play_idx = '0;
                        if (underflows != dbap_pkg::COUNT_MAX)
                            underflows = underflows + 16'd1;
                    end
                end
            end
            dbap_pkg::CMD_TIME: begin
                if (player_mode == dbap_pkg::PLAY_IDLE && idle_count != dbap_pkg::COUNT_MAX)
                    idle_count = idle_count + 16'd1;
            end
            default: begin
            end
        endcase

        // drain completion takes precedence over the mute check
        if (cmd != dbap_pkg::CMD_EOS && player_mode == dbap_pkg::PLAY_DRAIN &&
            !frame_full[0] && !frame_full[1]) begin
            player_mode       = dbap_pkg::PLAY_IDLE;
            idle_count        = '0;
            res.play_finished = 1'b1;
        end else if (player_mode == dbap_pkg::PLAY_IDLE && idle_count > mute_delay) begin
            amp_power = 1'b0;
        end

        res.amp_enabled     = amp_power;
        res.play_mode       = player_mode;
        res.underflow_total = underflows;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random stalls, checking of every transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) out_if.ready <= steady || ($urandom_range(99) >= GAP_PCT);

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t ns  %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    // values are sampled at the edge itself, before any register updates land
    always @(posedge i_clk) begin : result_check
        t_player_out want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_outputs.size() == 0) begin
                report_mismatch("result transfer with none pending", '0, '0);
            end else begin
                want = pending_outputs.pop_front();
                check_field("dac_valid", 16'(out_if.dac_valid), 16'(want.dac_valid));
                check_field("dac_word", out_if.dac_word, want.dac_word);
                check_field("byte_accepted", 16'(out_if.byte_accepted),
                            16'(want.byte_accepted));
                check_field("play_finished", 16'(out_if.play_finished),
                            16'(want.play_finished));
                check_field("amp_enabled", 16'(out_if.amp_enabled),
                            16'(want.amp_enabled));
                check_field("play_mode", 16'(out_if.play_mode), 16'(want.play_mode));
                check_field("underflow_total", out_if.underflow_total,
                            want.underflow_total);
            end
        end
    end

    // ------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------

    // one command transfer; valid stays high on return so back-to-back
    // transfers need no second assignment in the same step
    task automatic send_item(input logic [2:0] cmd, input logic [7:0] data,
                             input logic fend);
        while (!steady && $urandom_range(99) < GAP_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.command   <= cmd;
        in_if.data_byte <= data;
        in_if.frame_end <= fend;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pending_outputs.push_back(player_step(cmd, data, fend));
    endtask

    // stop sending and let every owed result come back
    task automatic wait_until_quiet();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_outputs.size() != 0) @(posedge i_clk);
        // pipeline is two deep, a little margin on top
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mute_delay(input logic [15:0] delay);
        wait_until_quiet();
        cfg_if.valid            <= 1'b1;
        cfg_if.mute_delay_ticks <= delay;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        mute_delay = delay;
        @(posedge i_clk);
    endtask

    task automatic tick_until_stopped();
        while (player_mode == dbap_pkg::PLAY_DRAIN)
            send_item(dbap_pkg::CMD_TICK, 8'h00, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // everything but start and time tick is ignored while idle
    task automatic test_idle_commands();
        send_item(dbap_pkg::CMD_NOP, 8'h00, 1'b0);
        send_item(CMD_SPARE_6, 8'hFF, 1'b1);
        send_item(CMD_SPARE_7, 8'h5A, 1'b0);
        send_item(dbap_pkg::CMD_TICK, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_TIME, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_FILL, 8'hFF, 1'b1);
        send_item(dbap_pkg::CMD_EOS, 8'h00, 1'b0);
    endtask

    // two short frames, a fill refused while the frame is busy, padding
    // past a short frame, end of stream ignored while draining
    task automatic test_short_frames();
        send_item(dbap_pkg::CMD_START, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_FILL, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_FILL, 8'hFF, 1'b1);
        send_item(dbap_pkg::CMD_FILL, 8'h12, 1'b1);
        send_item(dbap_pkg::CMD_FILL, 8'h34, 1'b0);
        send_item(dbap_pkg::CMD_TICK, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_TICK, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_TICK, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_EOS, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_EOS, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_FILL, 8'h77, 1'b1);
        send_item(dbap_pkg::CMD_TIME, 8'h00, 1'b0);
        tick_until_stopped();
    endtask

    // underflows, a partial frame closed by end of stream, restart while
    // draining and while running, drain completion on a non-tick command
    task automatic test_partial_frame_on_end();
        send_item(dbap_pkg::CMD_START, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_TICK, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_TICK, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_FILL, 8'hA5, 1'b0);
        send_item(dbap_pkg::CMD_FILL, 8'h5A, 1'b0);
        send_item(dbap_pkg::CMD_EOS, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_START, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_START, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_EOS, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_NOP, 8'h00, 1'b0);
    endtask

    // mute after the configured number of idle time ticks, not on the
    // transfer that ends the drain
    task automatic test_mute_delay();
        int n;
        write_mute_delay(16'h0000);
        send_item(dbap_pkg::CMD_START, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_EOS, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_NOP, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_TIME, 8'h00, 1'b0);

        write_mute_delay(16'd3);
        send_item(dbap_pkg::CMD_START, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_EOS, 8'h00, 1'b0);
        send_item(dbap_pkg::CMD_TIME, 8'h00, 1'b0);
        for (n = 0; n < 5; n++)
            send_item(dbap_pkg::CMD_TIME, 8'h00, 1'b0);
    endtask

    // one random command, weighted by what the player is doing so that
    // most of the traffic is real playback
    task automatic send_random_item(input int end_pct, input int eos_per_mille,
                                    output bit counted);
        int         roll;
        logic [2:0] cmd;
        logic       fend;
        roll = $urandom_range(999);
        if (player_mode == dbap_pkg::PLAY_RUN) begin
            if (roll < eos_per_mille)   cmd = dbap_pkg::CMD_EOS;
            else if (roll < 520)        cmd = dbap_pkg::CMD_FILL;
            else if (roll < 930)        cmd = dbap_pkg::CMD_TICK;
            else if (roll < 950)        cmd = dbap_pkg::CMD_START;
            else                        cmd = 3'($urandom_range(7));
        end else if (player_mode == dbap_pkg::PLAY_DRAIN) begin
            if (roll < 880)             cmd = dbap_pkg::CMD_TICK;
            else                        cmd = 3'($urandom_range(7));
        end else begin
            if (roll < 250)             cmd = dbap_pkg::CMD_START;
            else if (roll < 800)        cmd = dbap_pkg::CMD_TIME;
            else                        cmd = 3'($urandom_range(7));
        end
        if (cmd == dbap_pkg::CMD_FILL)
            fend = ($urandom_range(99) < end_pct);
        else
            fend = 1'($urandom_range(1));
        // noise that an idle player simply drops is not counted
        counted = !(player_mode == dbap_pkg::PLAY_IDLE && cmd != dbap_pkg::CMD_START &&
                    cmd != dbap_pkg::CMD_TIME);
        send_item(cmd, 8'($urandom_range(255)), fend);
    endtask

    task automatic test_random_playback();
        int          phase;
        int          sent;
        int          end_pct [4]       = '{5, 0, 30, 2};
        int          eos_per_mille [4] = '{10, 2, 20, 5};
        logic [15:0] delays [4];
        bit          counted;
        delays[0] = 16'($urandom_range(12, 2));
        delays[1] = 16'hFFFF;
        delays[2] = 16'h0000;
        delays[3] = 16'($urandom_range(40));
        for (phase = 0; phase < 4; phase++) begin
            write_mute_delay(delays[phase]);
            // a long stretch with no idling on either side
            steady = (phase == 2);
            sent   = 0;
            while (sent < RANDOM_ITEMS / 4) begin
                // now and then hold off until the block has caught up
                if ($urandom_range(99) == 0)
                    wait_until_quiet();
                send_random_item(end_pct[phase], eos_per_mille[phase], counted);
                if (counted)
                    sent++;
            end
        end
        steady = 1'b0;
        wait_until_quiet();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        steady                  = 1'b0;
        i_rst_n                 <= 1'b0;
        in_if.valid             <= 1'b0;
        in_if.command           <= dbap_pkg::CMD_NOP;
        in_if.data_byte         <= 8'h00;
        in_if.frame_end         <= 1'b0;
        cfg_if.valid            <= 1'b0;
        cfg_if.mute_delay_ticks <= dbap_pkg::MUTE_DELAY_RST;
        player_reset();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_commands();
        test_short_frames();
        test_partial_frame_on_end();
        test_mute_delay();
        test_random_playback();

        wait_until_quiet();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/dbap_pkg.sv
src/dbap_in_if.sv
src/dbap_out_if.sv
src/dbap_cfg_if.sv
src/dbap_front.sv
src/dbap_back.sv
src/double_buffer_audio_player.sv
bench/tb_double_buffer_audio_player.sv
